[hdl/kffba_pkg.sv]
package kffba_pkg;

  // Pool size and total limits
  localparam int NUM_SLOTS   = 128;
  localparam int VERT_LIMIT  = 1024;
  localparam int INDEX_LIMIT = 4096;

  // Field widths
  localparam int KEY_W  = 16;
  localparam int VC_W   = 11;
  localparam int IC_W   = 13;
  localparam int SLOT_W = 7;

  // Derived widths
  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int VT_W  = $clog2(VERT_LIMIT + 1);
  localparam int IT_W  = $clog2(INDEX_LIMIT + 1);
  localparam int VS_W  = ((VT_W > VC_W) ? VT_W : VC_W) + 1;
  localparam int IS_W  = ((IT_W > IC_W) ? IT_W : IC_W) + 1;

  // Stream widths
  localparam int S_TDATA_W = ((KEY_W + VC_W + IC_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((SLOT_W + 7) / 8) * 8;
  localparam int M_TUSER_W = 2;

  // Result flag positions in m_tuser
  localparam int M_GRANTED_BIT = 0;
  localparam int M_SHARED_BIT  = 1;

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  // One slot entry held in the store
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VT_W-1:0]  vt;
    logic [IT_W-1:0]  it;
  } entry_t;

  // Sequencer requests to the slot store
  typedef struct packed {
    idx_t   rd_addr;
    logic   wr_en;
    idx_t   wr_addr;
    entry_t wr_data;
    logic   clr_all;
  } store_req_t;

  // Compare and add unit results
  typedef struct packed {
    logic [VT_W-1:0] v_sat;
    logic [IT_W-1:0] i_sat;
    logic            fits;
    logic            key_eq;
  } alu_res_t;

endpackage

[hdl/kffba_alu.sv]
module kffba_alu
  import kffba_pkg::*;
(
  input  logic [KEY_W-1:0] key_a,
  input  logic [KEY_W-1:0] key_b,
  input  logic [VT_W-1:0]  vt_base,
  input  logic [VC_W-1:0]  vc,
  input  logic [IT_W-1:0]  it_base,
  input  logic [IC_W-1:0]  ic,
  output alu_res_t         res
);

  logic [VS_W-1:0] v_sum;
  logic [IS_W-1:0] i_sum;

  // Add the request counts to the slot totals
  assign v_sum = VS_W'(vt_base) + VS_W'(vc);
  assign i_sum = IS_W'(it_base) + IS_W'(ic);

  // Match needs the same key and both sums strictly below their limits
  assign res.key_eq = (key_a == key_b);
  assign res.fits   = (v_sum < VS_W'(VERT_LIMIT)) && (i_sum < IS_W'(INDEX_LIMIT));

  // Clamp the new totals at the limits
  assign res.v_sat = (v_sum > VS_W'(VERT_LIMIT)) ? VT_W'(VERT_LIMIT) : VT_W'(v_sum);
  assign res.i_sat = (i_sum > IS_W'(INDEX_LIMIT)) ? IT_W'(INDEX_LIMIT) : IT_W'(i_sum);

endmodule

[hdl/kffba_store.sv]
module kffba_store
  import kffba_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  store_req_t req,
  output entry_t     rd_data,
  output logic       rd_use
);

  entry_t               mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] in_use;

  // Key and totals memory, registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

  // In-use marks: cleared at once by reset or a clear command
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
      rd_use <= 1'b0;
    end else begin
      if (req.clr_all) begin
        in_use <= '0;
      end else if (req.wr_en) begin
        in_use[req.wr_addr] <= 1'b1;
      end
      rd_use <= in_use[req.rd_addr];
    end
  end

endmodule

[hdl/keyed_first_fit_buffer_allocator_top.sv]
// Keyed first-fit buffer allocator.
// Input channel s_*: one item per request. s_tuser carries the command
// (allocate or clear), s_tdata carries key, vertex count and index count.
// Output channel m_*: exactly one result item per input item. m_tdata holds
// the granted slot index, m_tuser holds the granted and shared flags.
// An allocate scans the slots in order through one compare and add unit,
// one slot per cycle from the registered read port of the slot memory.
// A request that reuses a slot ends its scan at the first matching slot;
// a request that takes a free slot or is refused scans all NUM_SLOTS
// slots. A clear goes straight to the final step, with no scan.
// s_tready is high only while no item is being worked on, so a new item
// is taken only once the last one has left the final step.
// Reset drops every in-use mark at once; keys and totals are left as they
// are and are only read for slots in use. A stalled receiver holds the
// result in the output register; the next item may be accepted meanwhile,
// and its result waits in the final step until the register is free.
module keyed_first_fit_buffer_allocator_top
  import kffba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // key, vert_count, index_count
  input  logic [0:0]           s_tuser,   // command
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // slot
  output logic [M_TUSER_W-1:0] m_tuser    // granted, shared
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t           state;
  logic [KEY_W-1:0] key_r;
  logic [VC_W-1:0]  vc_r;
  logic [IC_W-1:0]  ic_r;
  logic [CNT_W-1:0] cnt;
  logic             chk_vld;
  idx_t             chk_idx;
  logic             hit;
  logic             have_free;
  idx_t             pick;
  idx_t             free_idx;
  logic [VT_W-1:0]  wr_v;
  logic [IT_W-1:0]  wr_i;
  logic [SLOT_W-1:0] m_slot;

  store_req_t req;
  entry_t     rd_data;
  logic       rd_use;
  alu_res_t   alu;

  logic accept;
  logic issue;
  logic eval;
  logic match;
  logic is_free;
  logic last;
  logic out_free;
  logic grant;

  kffba_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data),
    .rd_use  (rd_use)
  );

  // Base totals come from memory while scanning, zero for a fresh slot
  kffba_alu u_alu (
    .key_a   (rd_data.key),
    .key_b   (key_r),
    .vt_base ((state == ST_SCAN) ? rd_data.vt : '0),
    .vc      (vc_r),
    .it_base ((state == ST_SCAN) ? rd_data.it : '0),
    .ic      (ic_r),
    .res     (alu)
  );

  // Handshake and scan decode
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign issue    = (state == ST_SCAN) && (cnt < CNT_W'(NUM_SLOTS));
  assign eval     = (state == ST_SCAN) && chk_vld;
  assign match    = eval && rd_use && alu.key_eq && alu.fits;
  assign is_free  = eval && !rd_use;
  assign last     = (chk_idx == idx_t'(NUM_SLOTS - 1));
  assign out_free = !m_tvalid || m_tready;
  assign grant    = hit || have_free;

  // Store requests
  always_comb begin
    req.rd_addr    = issue ? cnt[IDX_W-1:0] : '0;
    req.wr_en      = (state == ST_FINISH) && out_free && grant;
    req.wr_addr    = hit ? pick : free_idx;
    req.wr_data.key = key_r;
    req.wr_data.vt = hit ? wr_v : alu.v_sat;
    req.wr_data.it = hit ? wr_i : alu.i_sat;
    req.clr_all    = accept && (s_tuser[0] == CMD_CLEAR);
  end

  // Sequencer: take the item, walk the slots, hand over the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      chk_vld   <= 1'b0;
      hit       <= 1'b0;
      have_free <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            key_r     <= s_tdata[KEY_W-1:0];
            vc_r      <= s_tdata[KEY_W +: VC_W];
            ic_r      <= s_tdata[KEY_W + VC_W +: IC_W];
            cnt       <= '0;
            chk_vld   <= 1'b0;
            hit       <= 1'b0;
            have_free <= 1'b0;
            state     <= (s_tuser[0] == CMD_CLEAR) ? ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Advance the read address, track which slot the data is for
          if (issue) begin
            cnt     <= cnt + CNT_W'(1);
            chk_idx <= cnt[IDX_W-1:0];
            chk_vld <= 1'b1;
          end else begin
            chk_vld <= 1'b0;
          end
          // Note the lowest free slot
          if (is_free && !have_free) begin
            have_free <= 1'b1;
            free_idx  <= chk_idx;
          end
          // Stop on the first matching slot or after the last slot
          if (match) begin
            hit   <= 1'b1;
            pick  <= chk_idx;
            wr_v  <= alu.v_sat;
            wr_i  <= alu.i_sat;
            state <= ST_FINISH;
          end else if (eval && last) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: load the result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_FINISH) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && out_free) begin
      m_slot                 <= grant ? SLOT_W'(hit ? pick : free_idx) : '0;
      m_tuser[M_GRANTED_BIT] <= grant;
      m_tuser[M_SHARED_BIT]  <= hit;
    end
  end

  assign m_tdata = M_TDATA_W'(m_slot);

`ifndef SYNTH
  a_shared_grant: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[M_SHARED_BIT] |-> m_tuser[M_GRANTED_BIT])
    else $error("shared result without a grant");

  a_refuse_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[M_GRANTED_BIT] |-> (m_slot == '0))
    else $error("refused or clear result with nonzero slot");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("new item taken while one is at work");

  a_hit_finishes: assert property (@(posedge clk) disable iff (rst)
    match |=> (state == ST_FINISH) && hit)
    else $error("slot match did not end the scan");
`endif

endmodule
